// ===== design/swsm_pkg.sv =====
`timescale 1ns / 1ps
package swsm_pkg;

  localparam int MAX_POINTS   = 4096;
  localparam int POS_BITS     = $clog2(MAX_POINTS);
  localparam int COUNT_BITS   = POS_BITS + 1;
  localparam int SAMPLE_BITS  = 24;
  localparam int WAVELET_BITS = 18;
  localparam int FRAC_BITS    = 17;
  localparam int STEP_BITS    = 32;
  localparam int STEP_FRAC    = 16;
  localparam int IDX_PROD_BITS = STEP_BITS + POS_BITS;
  localparam int IDX_BITS     = IDX_PROD_BITS - STEP_FRAC;
  // operand is one bit wider so that the most negative value can be negated
  localparam int OPND_BITS    = SAMPLE_BITS + 1;
  localparam int PROD_BITS    = OPND_BITS + WAVELET_BITS;
  localparam int SHIFT_BITS   = PROD_BITS - FRAC_BITS;
  localparam int CFG_BITS     = 32;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_STEP     = 3'd0,
    REG_ENDPOINT = 3'd1,
    REG_SIZE     = 3'd2,
    REG_IMAG     = 3'd3,
    REG_DOUBLE   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_BIN  = 1'b1
  } command_t;

  localparam logic [STEP_BITS-1:0]  STEP_RESET = STEP_BITS'(65536);
  localparam logic [COUNT_BITS-1:0] SIZE_RESET = COUNT_BITS'(MAX_POINTS);

endpackage

// ===== design/scaled_wavelet_spectrum_multiply.sv =====
`timescale 1ns / 1ps
// Frequency-domain wavelet multiply for a continuous wavelet transform.
// Request channel (item_valid / item_stall): command 0 writes value_re
// (low 18 bits, Q1.17) into the wavelet table at position; command 1
// multiplies the bin (value_re, value_im) at offset position by the table
// sample at min(size-1, floor(step*position)), or by i times it in
// imaginary mode. Mirror bins go to size-1-position in double-sided mode
// and are dropped in single-sided mode. Bins at or past endpoint give zero.
// Result channel (result_valid / result_stall) carries out_position,
// out_re, out_im, shifted right by 17 and saturated to 24 bits.
// A request passes the stage 1, 2, 3 and output registers before its result
// is valid. Throughput: one request per cycle while the receiver does not stall;
// each stage holds one request, and stage 1 makes one table write or one
// table read for it. When the receiver stalls, the result holds and requests
// are still taken until the four pipeline slots fill; then item_stall rises.
// Reset (rst, synchronous) empties the pipeline and restores register
// defaults; the table is not cleared and must be written before it is read.
// Configuration writes (cfg_we) are to be issued only while idle.
module scaled_wavelet_spectrum_multiply import swsm_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          command,
  input  logic [POS_BITS-1:0]           position,
  input  logic                          mirror,
  input  logic signed [SAMPLE_BITS-1:0] value_re,
  input  logic signed [SAMPLE_BITS-1:0] value_im,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [POS_BITS-1:0]           out_position,
  output logic signed [SAMPLE_BITS-1:0] out_re,
  output logic signed [SAMPLE_BITS-1:0] out_im
);

  function automatic logic [SAMPLE_BITS-1:0] scale_sat(input logic [PROD_BITS-1:0] p);
    logic [SHIFT_BITS-1:0]              sh;
    logic [SHIFT_BITS-SAMPLE_BITS:0]    top;
    logic [SAMPLE_BITS-1:0]             res;
    sh  = p[PROD_BITS-1:FRAC_BITS];
    top = sh[SHIFT_BITS-1:SAMPLE_BITS-1];
    if (top == '0 || top == '1) begin
      res = sh[SAMPLE_BITS-1:0];
    end else if (sh[SHIFT_BITS-1]) begin
      res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  // configuration
  logic [STEP_BITS-1:0]  step_q16;
  logic [COUNT_BITS-1:0] endpoint;
  logic [COUNT_BITS-1:0] size_points;
  logic                  imaginary_mode;
  logic                  double_sided;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_q16       <= STEP_RESET;
      endpoint       <= '0;
      size_points    <= SIZE_RESET;
      imaginary_mode <= 1'b0;
      double_sided   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STEP:     step_q16       <= cfg_data[STEP_BITS-1:0];
        REG_ENDPOINT: endpoint       <= cfg_data[COUNT_BITS-1:0];
        REG_SIZE:     size_points    <= cfg_data[COUNT_BITS-1:0];
        REG_IMAG:     imaginary_mode <= cfg_data[0];
        REG_DOUBLE:   double_sided   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // size minus one, with zero treated as one and overlarge as the maximum
  logic [POS_BITS-1:0] size_m1;
  always_comb begin
    if (size_points == '0) begin
      size_m1 = '0;
    end else if (size_points > COUNT_BITS'(MAX_POINTS)) begin
      size_m1 = '1;
    end else begin
      size_m1 = POS_BITS'(size_points - COUNT_BITS'(1));
    end
  end

  // pipeline handshake
  logic valid1, valid2, valid3;
  logic load1;
  logic go_out, go3, go2, go1;
  logic accept, adv1;

  assign go_out     = !result_valid || !result_stall;
  assign go3        = !valid3 || go_out;
  assign go2        = !valid2 || go3;
  assign go1        = !valid1 || load1 || go2;
  assign item_stall = !go1;
  assign accept     = item_valid && go1;
  assign adv1       = valid1 && (load1 || go2);

  // stage 1: index product, output position, endpoint test
  logic [IDX_PROD_BITS-1:0]      idx_prod;
  logic [IDX_BITS-1:0]           idx1;
  logic [POS_BITS-1:0]           pos1;
  logic                          zero1;
  logic signed [SAMPLE_BITS-1:0] re1, im1;

  assign idx_prod = IDX_PROD_BITS'(step_q16) * IDX_PROD_BITS'(position);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (go1) begin
      // drop mirror bins in single-sided mode
      valid1 <= item_valid &&
                !(command == CMD_BIN && mirror && !double_sided);
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      load1 <= (command == CMD_LOAD);
      idx1  <= idx_prod[IDX_PROD_BITS-1:STEP_FRAC];
      // loads always write at position; only bins are mirrored
      pos1  <= (command == CMD_BIN && mirror) ? POS_BITS'(size_m1 - position) : position;
      zero1 <= (COUNT_BITS'(position) >= endpoint);
      re1   <= value_re;
      im1   <= value_im;
    end
  end

  // stage 1 to 2: table write or read
  logic [POS_BITS-1:0]     rd_addr;
  logic                    mem_we, mem_re;
  logic [WAVELET_BITS-1:0] sample2;

  assign rd_addr = (idx1 > IDX_BITS'(size_m1)) ? size_m1 : idx1[POS_BITS-1:0];
  assign mem_we  = valid1 && load1;
  assign mem_re  = valid1 && !load1 && go2;

  swsm_ram #(
    .WIDTH (WAVELET_BITS),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pos1),
    .wdata (re1[WAVELET_BITS-1:0]),
    .re    (mem_re),
    .raddr (rd_addr),
    .rdata (sample2)
  );

  // multiplier operands: i*s*(re + j*im) = s*(-im + j*re)
  logic signed [OPND_BITS-1:0] opnd_re, opnd_im;
  logic signed [OPND_BITS-1:0] a_re2, a_im2;
  logic [POS_BITS-1:0]         pos2;
  logic                        zero2;

  always_comb begin
    if (imaginary_mode) begin
      opnd_re = -OPND_BITS'(im1);
      opnd_im = OPND_BITS'(re1);
    end else begin
      opnd_re = OPND_BITS'(re1);
      opnd_im = OPND_BITS'(im1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (go2) begin
      valid2 <= valid1 && !load1;
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      a_re2 <= opnd_re;
      a_im2 <= opnd_im;
      pos2  <= pos1;
      zero2 <= zero1;
    end
  end

  // stage 3: products
  logic signed [PROD_BITS-1:0] p_re3, p_im3;
  logic [POS_BITS-1:0]         pos3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid3 <= 1'b0;
    end else if (go3) begin
      valid3 <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (go3) begin
      // bins past endpoint ignore the sample they read
      if (zero2) begin
        p_re3 <= '0;
        p_im3 <= '0;
      end else begin
        p_re3 <= PROD_BITS'(a_re2) * PROD_BITS'($signed(sample2));
        p_im3 <= PROD_BITS'(a_im2) * PROD_BITS'($signed(sample2));
      end
      pos3  <= pos2;
    end
  end

  // output register: shift, saturate, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go_out) begin
      result_valid <= valid3;
    end
  end

  always_ff @(posedge clk) begin
    if (go_out) begin
      out_position <= pos3;
      out_re       <= scale_sat(p_re3);
      out_im       <= scale_sat(p_im3);
    end
  end

endmodule

// ===== design/swsm_ram.sv =====
`timescale 1ns / 1ps
module swsm_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
